// File: rtl/jst_pkg.sv
// Shared types and constants for the JSON stream tokenizer.
// Used by jst_front, jst_queue, jst_back and json_stream_tokenizer_top.
`default_nettype none
package jst_pkg;

    localparam logic [3:0] EV_STRB   = 4'd0;
    localparam logic [3:0] EV_STRE   = 4'd1;
    localparam logic [3:0] EV_NUMB   = 4'd2;
    localparam logic [3:0] EV_NUME   = 4'd3;
    localparam logic [3:0] EV_NULL   = 4'd4;
    localparam logic [3:0] EV_AOPEN  = 4'd7;
    localparam logic [3:0] EV_ACLOSE = 4'd8;
    localparam logic [3:0] EV_OOPEN  = 4'd9;
    localparam logic [3:0] EV_OCLOSE = 4'd10;
    localparam logic [3:0] EV_OK     = 4'd11;
    localparam logic [3:0] EV_ERR    = 4'd12;

    localparam logic [3:0] ER_NONE   = 4'd0;
    localparam logic [3:0] ER_EARLY  = 4'd1;
    localparam logic [3:0] ER_LIT    = 4'd2;
    localparam logic [3:0] ER_ESC    = 4'd3;
    localparam logic [3:0] ER_HEX    = 4'd4;
    localparam logic [3:0] ER_NUM    = 4'd5;
    localparam logic [3:0] ER_ASEP   = 4'd6;
    localparam logic [3:0] ER_KEY    = 4'd7;
    localparam logic [3:0] ER_COLON  = 4'd8;
    localparam logic [3:0] ER_OSEP   = 4'd9;
    localparam logic [3:0] ER_CHAR   = 4'd10;
    localparam logic [3:0] ER_TRAIL  = 4'd11;
    localparam logic [3:0] ER_DEEP   = 4'd12;

    // one result event
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] pay;
        logic       key;
        logic [3:0] err;
        logic [5:0] lvl;
        logic       last;
    } ev_t;

    // bundle of up to four events caused by one byte
    typedef struct packed {
        logic [2:0] cnt;
        ev_t [3:0]  ev;
    } evgrp_t;

    function automatic ev_t mk_ev(logic [3:0] kind, logic [7:0] pay, logic key,
                                  logic [3:0] err, logic [5:0] lvl);
        ev_t e;
        e.kind = kind;
        e.pay  = pay;
        e.key  = key;
        e.err  = err;
        e.lvl  = lvl;
        e.last = 1'b0;
        return e;
    endfunction

endpackage
`default_nettype wire

// File: rtl/json_stream_tokenizer_top.sv
// JSON stream tokenizer: one document byte per cycle in, token events out.
// Depends on jst_pkg, jst_front, jst_queue, jst_back.
// A byte is taken every cycle while the event queue has room; a byte causes zero to
// four events, and the output side delivers one event per cycle while m_tready is
// high, so sustained input rate is one byte per cycle as long as bytes average at most
// one event. The first event of a byte passes the front register, which loads at the
// edge that accepts the byte, then the queue, then the output register.
`default_nettype none
module json_stream_tokenizer_top #(
    parameter int MAX_DEPTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,   // text_byte
    input  wire         s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // event_kind, payload_byte, string_is_key,
                                   // error_code, nesting_level, zero pad
    output logic        m_tlast    // run_last
);
    jst_pkg::evgrp_t f_grp, q_grp;
    logic f_valid, f_ready, q_valid, q_ready;
    jst_pkg::ev_t ev;

    jst_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .text_byte(s_tdata), .end_of_text(s_tlast),
        .grp_valid(f_valid), .grp_ready(f_ready), .grp(f_grp));

    jst_queue u_queue (
        .aclk, .aresetn, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_grp),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_grp));

    jst_back u_back (
        .aclk, .aresetn, .grp_valid(q_valid), .grp_ready(q_ready), .grp(q_grp),
        .ev_valid(m_tvalid), .ev_ready(m_tready), .ev(ev));

    assign m_tdata = {1'b0, ev.lvl, ev.err, ev.key, ev.pay, ev.kind};
    assign m_tlast = ev.last;
endmodule
`default_nettype wire

// File: rtl/jst_front.sv
// Front part: parses one byte per cycle while the queue has room, producing its events.
// Depends on jst_pkg.
`default_nettype none
module jst_front #(
    parameter int MAX_DEPTH = 32
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire [7:0]        text_byte,
    input  wire              end_of_text,
    output logic             grp_valid,
    input  wire              grp_ready,
    output jst_pkg::evgrp_t  grp
);
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam logic [3:0] M_ROOT  = 4'd0;
    localparam logic [3:0] M_VALUE = 4'd1;
    localparam logic [3:0] M_AFIRST = 4'd2;
    localparam logic [3:0] M_OFIRST = 4'd3;
    localparam logic [3:0] M_KEY   = 4'd4;
    localparam logic [3:0] M_COLON = 4'd5;
    localparam logic [3:0] M_AFTER = 4'd6;
    localparam logic [3:0] M_STR   = 4'd7;
    localparam logic [3:0] M_ESC   = 4'd8;
    localparam logic [3:0] M_HEX   = 4'd9;
    localparam logic [3:0] M_LIT   = 4'd10;
    localparam logic [3:0] M_NUM   = 4'd11;

    logic [3:0]   mode_reg, mode_next;
    logic         key_reg, key_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [2:0]   lprog_reg, lprog_next;
    logic [1:0]   lwhich_reg, lwhich_next;
    logic [11:0]  uval_reg, uval_next;
    logic [1:0]   hexcnt_reg, hexcnt_next;
    logic [2:0]   nph_reg, nph_next;
    logic         err_reg, err_next;
    logic [MAX_DEPTH-1:0] stack_reg;
    logic         push;
    logic         push_obj;
    logic         top_obj;

    jst_pkg::evgrp_t g;
    logic [15:0]  cp;
    logic [3:0]   hv;
    logic         hok;
    logic [3:0]   base;
    logic [3:0]   nn;
    logic         num_cont;
    logic         done;
    logic [7:0]   c;
    logic         ws, dig;
    logic [7:0]   lit_ch;
    logic [2:0]   lit_len;
    logic [7:0]   escv;
    logic [1:0]   esck;  // 0 bad, 1 plain, 2 unicode

    assign c = text_byte;
    assign in_ready = grp_ready;
    assign ws  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    assign dig = (c >= "0") && (c <= "9");
    assign top_obj = (depth_reg != '0) ? stack_reg[AW'(depth_reg - DW'(1))] : 1'b0;

    function automatic logic cpl(logic [2:0] ph);
        return (ph == 3'd1) || (ph == 3'd2) || (ph == 3'd4) || (ph == 3'd7);
    endfunction

    always_comb begin
        // literal text lookup
        unique case (lwhich_reg)
            2'd1: begin
                lit_len = 3'd4;
                case (lprog_reg)
                    3'd1: lit_ch = "r";
                    3'd2: lit_ch = "u";
                    default: lit_ch = "e";
                endcase
            end
            2'd2: begin
                lit_len = 3'd5;
                case (lprog_reg)
                    3'd1: lit_ch = "a";
                    3'd2: lit_ch = "l";
                    3'd3: lit_ch = "s";
                    default: lit_ch = "e";
                endcase
            end
            default: begin
                lit_len = 3'd4;
                case (lprog_reg)
                    3'd1: lit_ch = "u";
                    default: lit_ch = "l";
                endcase
            end
        endcase
        hok = 1'b1;
        if (dig) hv = 4'(c - "0");
        else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
        else begin
            hv = 4'd0;
            hok = 1'b0;
        end
        esck = 2'd1;
        escv = c;
        case (c)
            "\"", "\\", "/": escv = c;
            "b": escv = 8'h08;
            "f": escv = 8'h0C;
            "n": escv = 8'h0A;
            "r": escv = 8'h0D;
            "t": escv = 8'h09;
            "u": esck = 2'd2;
            default: esck = 2'd0;
        endcase
        num_cont = 1'b1;
        nn = 4'd0;
        case (nph_reg)
            3'd0: if (c == "0") nn = 4'd1; else if (dig) nn = 4'd2; else num_cont = 1'b0;
            3'd1: if (c == ".") nn = 4'd3; else if (c == "e" || c == "E") nn = 4'd5;
                  else num_cont = 1'b0;
            3'd2: if (dig) nn = 4'd2; else if (c == ".") nn = 4'd3;
                  else if (c == "e" || c == "E") nn = 4'd5; else num_cont = 1'b0;
            3'd3: if (dig) nn = 4'd4; else num_cont = 1'b0;
            3'd4: if (dig) nn = 4'd4; else if (c == "e" || c == "E") nn = 4'd5;
                  else num_cont = 1'b0;
            3'd5: if (c == "+" || c == "-") nn = 4'd6; else if (dig) nn = 4'd7;
                  else num_cont = 1'b0;
            default: if (dig) nn = 4'd7; else num_cont = 1'b0;
        endcase
        cp = {uval_reg, hv};
    end

    // byte handling; events appended in order
    always_comb begin
        mode_next   = mode_reg;
        key_next    = key_reg;
        depth_next  = depth_reg;
        lprog_next  = lprog_reg;
        lwhich_next = lwhich_reg;
        uval_next   = uval_reg;
        hexcnt_next = hexcnt_reg;
        nph_next    = nph_reg;
        err_next    = err_reg;
        push        = 1'b0;
        push_obj    = 1'b0;
        g           = '0;
        done        = 1'b0;
        base        = mode_reg;

        if (!err_reg) begin
            if (base == M_NUM) begin
                if (num_cont) begin
                    nph_next = nn[2:0];
                    g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_NUMB, c, 1'b0, jst_pkg::ER_NONE,
                                             6'(depth_reg));
                    g.cnt = 3'd1;
                    done = 1'b1;
                end else if (!cpl(nph_reg)) begin
                    g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0, jst_pkg::ER_NUM,
                                             6'(depth_reg));
                    g.cnt = 3'd1;
                    err_next = 1'b1;
                    done = 1'b1;
                end else begin
                    g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_NUME, 8'd0, 1'b0, jst_pkg::ER_NONE,
                                             6'(depth_reg));
                    g.cnt = 3'd1;
                    nph_next = 3'd0;
                    mode_next = M_AFTER;
                    key_next = 1'b0;
                    base = M_AFTER;
                end
            end
            if (!done) begin
                unique case (base)
                    M_LIT: begin
                        if (c == lit_ch) begin
                            lprog_next = lprog_reg + 3'd1;
                            if (lprog_next == lit_len) begin
                                g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_NULL + 4'(lwhich_reg),
                                    8'd0, 1'b0, jst_pkg::ER_NONE, 6'(depth_reg));
                                g.cnt = 3'd1;
                                lprog_next = 3'd0;
                                mode_next = M_AFTER;
                            end
                        end else begin
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                     jst_pkg::ER_LIT, 6'(depth_reg));
                            g.cnt = 3'd1;
                            err_next = 1'b1;
                        end
                    end
                    M_OFIRST, M_KEY: begin
                        if (!ws) begin
                            if (c == "\"") begin
                                mode_next = M_STR;
                                key_next = 1'b1;
                            end else if (c == "}" && base == M_OFIRST) begin
                                depth_next = depth_reg - DW'(1);
                                g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_OCLOSE, 8'd0, 1'b0,
                                                         jst_pkg::ER_NONE, 6'(depth_next));
                                g.cnt = 3'd1;
                                mode_next = M_AFTER;
                            end else begin
                                g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                         jst_pkg::ER_KEY, 6'(depth_reg));
                                g.cnt = 3'd1;
                                err_next = 1'b1;
                            end
                        end
                    end
                    M_COLON: begin
                        if (!ws) begin
                            if (c == ":") mode_next = M_VALUE;
                            else begin
                                g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                         jst_pkg::ER_COLON, 6'(depth_reg));
                                g.cnt = 3'd1;
                                err_next = 1'b1;
                            end
                        end
                    end
                    M_AFTER: begin
                        if (!ws) begin
                            if (depth_reg == '0) begin
                                g.ev[g.cnt[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                    jst_pkg::ER_TRAIL, 6'(depth_reg));
                                g.cnt = g.cnt + 3'd1;
                                err_next = 1'b1;
                            end else if (c == ",") begin
                                mode_next = top_obj ? M_KEY : M_VALUE;
                            end else if ((c == "]" && !top_obj) || (c == "}" && top_obj)) begin
                                depth_next = depth_reg - DW'(1);
                                g.ev[g.cnt[1:0]] = jst_pkg::mk_ev(
                                    top_obj ? jst_pkg::EV_OCLOSE : jst_pkg::EV_ACLOSE,
                                    8'd0, 1'b0, jst_pkg::ER_NONE, 6'(depth_next));
                                g.cnt = g.cnt + 3'd1;
                                mode_next = M_AFTER;
                            end else begin
                                g.ev[g.cnt[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                    top_obj ? jst_pkg::ER_OSEP : jst_pkg::ER_ASEP,
                                    6'(depth_reg));
                                g.cnt = g.cnt + 3'd1;
                                err_next = 1'b1;
                            end
                        end
                    end
                    M_STR: begin
                        if (c == "\"") begin
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_STRE, 8'd0, key_reg,
                                                     jst_pkg::ER_NONE, 6'(depth_reg));
                            g.cnt = 3'd1;
                            mode_next = key_reg ? M_COLON : M_AFTER;
                            key_next = 1'b0;
                        end else if (c == "\\") begin
                            mode_next = M_ESC;
                        end else if (c < 8'h20) begin
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                     jst_pkg::ER_CHAR, 6'(depth_reg));
                            g.cnt = 3'd1;
                            err_next = 1'b1;
                        end else begin
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_STRB, c, key_reg,
                                                     jst_pkg::ER_NONE, 6'(depth_reg));
                            g.cnt = 3'd1;
                        end
                    end
                    M_ESC: begin
                        if (esck == 2'd0) begin
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                     jst_pkg::ER_ESC, 6'(depth_reg));
                            g.cnt = 3'd1;
                            err_next = 1'b1;
                        end else if (esck == 2'd2) begin
                            uval_next = '0;
                            hexcnt_next = '0;
                            mode_next = M_HEX;
                        end else begin
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_STRB, escv, key_reg,
                                                     jst_pkg::ER_NONE, 6'(depth_reg));
                            g.cnt = 3'd1;
                            mode_next = M_STR;
                        end
                    end
                    M_HEX: begin
                        if (!hok) begin
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                     jst_pkg::ER_HEX, 6'(depth_reg));
                            g.cnt = 3'd1;
                            err_next = 1'b1;
                        end else if (hexcnt_reg == 2'd3) begin
                            uval_next = '0;
                            hexcnt_next = '0;
                            mode_next = M_STR;
                            if (cp < 16'h0080) begin
                                g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_STRB, cp[7:0], key_reg,
                                                         jst_pkg::ER_NONE, 6'(depth_reg));
                                g.cnt = 3'd1;
                            end else if (cp <= 16'h07FF) begin
                                g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_STRB,
                                    {3'b110, cp[10:6]}, key_reg, jst_pkg::ER_NONE,
                                    6'(depth_reg));
                                g.ev[1] = jst_pkg::mk_ev(jst_pkg::EV_STRB,
                                    {2'b10, cp[5:0]}, key_reg, jst_pkg::ER_NONE,
                                    6'(depth_reg));
                                g.cnt = 3'd2;
                            end else begin
                                g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_STRB,
                                    {4'b1110, cp[15:12]}, key_reg, jst_pkg::ER_NONE,
                                    6'(depth_reg));
                                g.ev[1] = jst_pkg::mk_ev(jst_pkg::EV_STRB,
                                    {2'b10, cp[11:6]}, key_reg, jst_pkg::ER_NONE,
                                    6'(depth_reg));
                                g.ev[2] = jst_pkg::mk_ev(jst_pkg::EV_STRB,
                                    {2'b10, cp[5:0]}, key_reg, jst_pkg::ER_NONE,
                                    6'(depth_reg));
                                g.cnt = 3'd3;
                            end
                        end else begin
                            uval_next = cp[11:0];
                            hexcnt_next = hexcnt_reg + 2'd1;
                        end
                    end
                    default: begin
                        // root, value, first array element
                        if (ws) begin
                            // skip
                        end else if (base == M_AFIRST && c == "]") begin
                            depth_next = depth_reg - DW'(1);
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ACLOSE, 8'd0, 1'b0,
                                                     jst_pkg::ER_NONE, 6'(depth_next));
                            g.cnt = 3'd1;
                            mode_next = M_AFTER;
                        end else if (c == "n" || c == "t" || c == "f") begin
                            lwhich_next = (c == "n") ? 2'd0 : ((c == "t") ? 2'd1 : 2'd2);
                            lprog_next = 3'd1;
                            mode_next = M_LIT;
                        end else if (c == "\"") begin
                            mode_next = M_STR;
                            key_next = 1'b0;
                        end else if (c == "[" || c == "{") begin
                            if (depth_reg >= DW'(MAX_DEPTH)) begin
                                g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                         jst_pkg::ER_DEEP, 6'(depth_reg));
                                g.cnt = 3'd1;
                                err_next = 1'b1;
                            end else begin
                                push = 1'b1;
                                push_obj = (c == "{");
                                depth_next = depth_reg + DW'(1);
                                g.ev[0] = jst_pkg::mk_ev(push_obj ? jst_pkg::EV_OOPEN :
                                    jst_pkg::EV_AOPEN, 8'd0, 1'b0, jst_pkg::ER_NONE,
                                    6'(depth_next));
                                g.cnt = 3'd1;
                                mode_next = push_obj ? M_OFIRST : M_AFIRST;
                            end
                        end else if (c == "-" || dig) begin
                            nph_next = (c == "-") ? 3'd0 : ((c == "0") ? 3'd1 : 3'd2);
                            mode_next = M_NUM;
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_NUMB, c, 1'b0,
                                                     jst_pkg::ER_NONE, 6'(depth_reg));
                            g.cnt = 3'd1;
                        end else begin
                            g.ev[0] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                     jst_pkg::ER_CHAR, 6'(depth_reg));
                            g.cnt = 3'd1;
                            err_next = 1'b1;
                        end
                    end
                endcase
            end
            // final byte closes the document
            if (end_of_text && !err_next) begin
                if (mode_next == M_NUM && !cpl(nph_next)) begin
                    g.ev[g.cnt[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                                                      jst_pkg::ER_NUM, 6'(depth_next));
                    g.cnt = g.cnt + 3'd1;
                end else begin
                    if (mode_next == M_NUM) begin
                        g.ev[g.cnt[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_NUME, 8'd0, 1'b0,
                            jst_pkg::ER_NONE, 6'(depth_next));
                        g.cnt = g.cnt + 3'd1;
                    end
                    if ((mode_next == M_NUM || mode_next == M_AFTER) && depth_next == '0)
                        g.ev[g.cnt[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_OK, 8'd0, 1'b0,
                            jst_pkg::ER_NONE, 6'(depth_next));
                    else
                        g.ev[g.cnt[1:0]] = jst_pkg::mk_ev(jst_pkg::EV_ERR, 8'd0, 1'b0,
                            (mode_next == M_OFIRST || mode_next == M_KEY) ? jst_pkg::ER_KEY :
                            (mode_next == M_COLON) ? jst_pkg::ER_COLON :
                            (mode_next == M_LIT) ? jst_pkg::ER_LIT : jst_pkg::ER_EARLY,
                            6'(depth_next));
                    g.cnt = g.cnt + 3'd1;
                end
            end
            if (g.cnt != 3'd0) g.ev[2'(g.cnt - 3'd1)].last = 1'b1;
        end
        if (end_of_text) begin
            mode_next   = M_ROOT;
            key_next    = 1'b0;
            depth_next  = '0;
            lprog_next  = '0;
            lwhich_next = '0;
            uval_next   = '0;
            hexcnt_next = '0;
            nph_next    = '0;
            err_next    = 1'b0;
        end
    end

    // the queue always takes the held group, so the valid lasts one cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_ROOT;
            key_reg    <= 1'b0;
            depth_reg  <= '0;
            lprog_reg  <= '0;
            lwhich_reg <= '0;
            uval_reg   <= '0;
            hexcnt_reg <= '0;
            nph_reg    <= '0;
            err_reg    <= 1'b0;
            grp_valid  <= 1'b0;
        end else begin
            grp_valid <= in_ready && in_valid && (g.cnt != 3'd0);
            if (in_ready && in_valid) begin
                mode_reg   <= mode_next;
                key_reg    <= key_next;
                depth_reg  <= depth_next;
                lprog_reg  <= lprog_next;
                lwhich_reg <= lwhich_next;
                uval_reg   <= uval_next;
                hexcnt_reg <= hexcnt_next;
                nph_reg    <= nph_next;
                err_reg    <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            grp <= g;
            if (push) stack_reg[AW'(depth_reg)] <= push_obj;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) depth_reg <= DW'(MAX_DEPTH))
        else $error("depth beyond limit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && end_of_text) |=> (depth_reg == '0 && !err_reg))
        else $error("state not cleared after final byte");
    assert property (@(posedge aclk) disable iff (!aresetn)
        grp_valid |-> (grp.cnt != 3'd0 && grp.cnt <= 3'd4))
        else $error("bad event count");
endmodule
`default_nettype wire

// File: rtl/jst_queue.sv
// Short FIFO of event groups between front and back parts.
// Depends on jst_pkg.
`default_nettype none
module jst_queue (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              wr_valid,
    output logic             wr_ready,
    input  jst_pkg::evgrp_t  wr_data,
    output logic             rd_valid,
    input  wire              rd_ready,
    output jst_pkg::evgrp_t  rd_data
);
    jst_pkg::evgrp_t mem_reg [4];
    logic [2:0] wp_reg, rp_reg;
    logic [2:0] fill;

    assign fill     = wp_reg - rp_reg;
    // keep one slot back for the group still in the front register
    assign wr_ready = (fill < 3'd3);
    assign rd_valid = (fill != 3'd0);
    assign rd_data  = mem_reg[rp_reg[1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (wr_valid) wp_reg <= wp_reg + 3'd1;
            if (rd_valid && rd_ready) rp_reg <= rp_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid) mem_reg[wp_reg[1:0]] <= wr_data;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) fill <= 3'd4)
        else $error("queue overflow");
endmodule
`default_nettype wire

// File: rtl/jst_back.sv
// Back part: unrolls each event group into single events on the output stream.
// Depends on jst_pkg.
`default_nettype none
module jst_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              grp_valid,
    output logic             grp_ready,
    input  jst_pkg::evgrp_t  grp,
    output logic             ev_valid,
    input  wire              ev_ready,
    output jst_pkg::ev_t     ev
);
    logic [1:0] idx_reg;
    logic       take;

    assign take      = grp_valid && (!ev_valid || ev_ready);
    assign grp_ready = take && (3'(idx_reg) + 3'd1 == grp.cnt);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            ev_valid <= 1'b0;
        end else begin
            if (take) begin
                ev_valid <= 1'b1;
                idx_reg  <= grp_ready ? 2'd0 : idx_reg + 2'd1;
            end else if (ev_ready) begin
                ev_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) ev <= grp.ev[idx_reg];
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ev_valid && !ev_ready) |=> ev_valid)
        else $error("event dropped");
endmodule
`default_nettype wire
